### src/samb_pkg.sv
// Shared types and constants for the set-associative cache tag store.
`default_nettype none

package samb_pkg;

    // defaults for the top-level parameters
    localparam int DEF_SETS      = 16;
    localparam int DEF_WAYS      = 4;
    localparam int DEF_ADDR_BITS = 32;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int LOB_W      = 4;
    localparam int SB_W       = 3;
    localparam int WIU_W      = 3;

    // register reset values and limits
    localparam logic [LOB_W-1:0] LOB_RESET = 4'd2;
    localparam logic [SB_W-1:0]  SB_RESET  = 3'd4;
    localparam logic [WIU_W-1:0] WIU_RESET = 3'd4;
    localparam logic [LOB_W-1:0] OFF_MAX   = 4'd12;

    // fixed result field widths
    localparam int WAY_OUT_W = 2;
    localparam int SET_OUT_W = 4;
    localparam int CNT_W     = 32;
    localparam int PADDR_W   = 32;

    // request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INVAL  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_OFFSET = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

### src/samb_tag_ram.sv
// Single-port-write, single-port-read set memory with registered read data.
`default_nettype none

module samb_tag_ram
    import samb_pkg::*;
#(
    parameter int DEPTH = DEF_SETS,
    parameter int AW    = 4,
    parameter int DW    = 136
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old row when the same address is written this edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/samb_addr_split.sv
// Splits a byte address into set index and tag under the current geometry.
`default_nettype none

module samb_addr_split
    import samb_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SET_BITS  = 4,
    parameter int SET_IW    = 4
) (
    input  wire logic [ADDR_BITS-1:0] phys_addr,
    input  wire logic [LOB_W-1:0]     line_offset_bits,
    input  wire logic [SB_W-1:0]      set_bits,
    output logic      [SET_IW-1:0]    set_idx,
    output logic      [ADDR_BITS-1:0] tag
);

    localparam int LW = (ADDR_BITS > SET_IW) ? ADDR_BITS : SET_IW;

    logic [LOB_W-1:0]     off;
    logic [SB_W-1:0]      sb;
    logic [ADDR_BITS-1:0] line;
    logic [LW-1:0]        line_ext;
    logic [SET_IW-1:0]    mask;

    always_comb begin
        off = (line_offset_bits > OFF_MAX) ? OFF_MAX : line_offset_bits;
        sb  = (int'(set_bits) > SET_BITS) ? SB_W'(SET_BITS) : set_bits;
        line     = phys_addr >> off;
        line_ext = LW'(line);
        for (int i = 0; i < SET_IW; i++) begin
            mask[i] = (i < int'(sb));
        end
        set_idx = line_ext[SET_IW-1:0] & mask;
        tag     = line >> sb;
    end

endmodule

`default_nettype wire

### src/samb_way_logic.sv
// Per-set hit detection, victim choice and MRU/valid/tag update for one request.
`default_nettype none

module samb_way_logic
    import samb_pkg::*;
#(
    parameter int WAYS  = DEF_WAYS,
    parameter int TAG_W = DEF_ADDR_BITS,
    parameter int WAY_W = 2,
    parameter int ROW_W = DEF_WAYS * (DEF_ADDR_BITS + 2)
) (
    input  wire logic             req_type,
    input  wire logic [TAG_W-1:0] tag,
    input  wire logic [WIU_W-1:0] ways_in_use,
    input  wire logic [ROW_W-1:0] row_in,
    output logic                  hit,
    output logic      [WAY_W-1:0] way,
    output logic      [ROW_W-1:0] row_out
);

    localparam int VLD_LO = WAYS * TAG_W;
    localparam int MRU_LO = VLD_LO + WAYS;

    function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] v);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (v[w]) begin
                idx = WAY_W'(w);
            end
        end
        return idx;
    endfunction

    logic [WIU_W-1:0] wiu;
    logic             multi;
    logic [WAYS-1:0]  in_use;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  vld;
    logic [WAYS-1:0]  mru;
    logic [WAYS-1:0]  hit_vec;
    logic [WAYS-1:0]  free_vec;
    logic [WAYS-1:0]  old_vec;
    logic [WAYS-1:0]  sel_oh;
    logic [WAYS-1:0]  marked;

    always_comb begin
        wiu   = (ways_in_use == '0) ? WIU_W'(1) : ways_in_use;
        multi = (int'(wiu) > 1) && (WAYS > 1);
        vld   = row_in[VLD_LO +: WAYS];
        mru   = row_in[MRU_LO +: WAYS];
        for (int w = 0; w < WAYS; w++) begin
            in_use[w] = (w < int'(wiu));
            match[w]  = in_use[w] && (row_in[w*TAG_W +: TAG_W] == tag);
        end
        hit_vec  = match & vld;
        free_vec = in_use & ~vld;
        old_vec  = in_use & ~mru;

        row_out = row_in;
        hit     = 1'b0;
        way     = '0;
        sel_oh  = '0;
        marked  = mru;

        if (req_type == REQ_INVAL) begin
            // drop every matching way, valid or not
            hit = |match;
            way = first_one(match);
            row_out[VLD_LO +: WAYS] = vld & ~match;
            row_out[MRU_LO +: WAYS] = mru & ~match;
        end else begin
            if (|hit_vec) begin
                hit = 1'b1;
                way = first_one(hit_vec);
            end else if (|free_vec) begin
                way = first_one(free_vec);
            end else if (multi && (|old_vec)) begin
                way = first_one(old_vec);
            end else begin
                // direct mapped, or every way marked: way 0
                way = '0;
            end
            sel_oh = WAYS'(1) << way;
            marked = mru | sel_oh;
            if ((marked & in_use) == in_use) begin
                marked = (marked & ~in_use) | sel_oh;
            end
            row_out[VLD_LO +: WAYS]      = vld | sel_oh;
            row_out[MRU_LO +: WAYS]      = marked;
            row_out[way*TAG_W +: TAG_W]  = tag;
        end
    end

endmodule

`default_nettype wire

### src/set_assoc_cache_mru_bits.sv
// Top level of the set-associative cache tag store with MRU-bit replacement.
`default_nettype none

// Tag store for a set-associative cache with MRU-bit (bit pseudo-LRU)
// replacement. Each item is a lookup (req_type 0) or an invalidate (req_type 1)
// of a byte address; each item yields exactly one result item carrying hit,
// the way used, the set index and the running hit/miss counts. The design
// takes one item per clock while m_ready does not hold it back: the set row
// (tags, valid and MRU bits of all ways) is read from a registered-read
// memory in the accept cycle, resolved and written back when the item leaves
// the resolve stage, with the row just written forwarded when consecutive
// items hit the same set. An accepted item passes the resolve stage register
// and then the result register, where m_valid rises; the one set-row memory
// port pair is what bounds the design to one item per cycle. After reset the
// block clears the set memory one row per cycle and holds s_ready low until
// every row is cleared. Configuration registers (line offset bits, set bits,
// ways in use) may only be written while no item is in flight.
module set_assoc_cache_mru_bits
    import samb_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // request items
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [PADDR_W-1:0]    s_phys_addr,
    // result items
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic      [WAY_OUT_W-1:0]  m_way_used,
    output logic      [SET_OUT_W-1:0]  m_set_index,
    output logic      [CNT_W-1:0]      m_hit_total,
    output logic      [CNT_W-1:0]      m_miss_total
);

    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = ADDR_BITS;
    localparam int ROW_W    = WAYS * (TAG_W + 2);
    localparam int VLD_LO   = WAYS * TAG_W;
    localparam int MRU_LO   = VLD_LO + WAYS;
    localparam logic [SET_IW-1:0] LAST_SET = SET_IW'(SETS - 1);

    // configuration registers
    logic [LOB_W-1:0] lob_reg;
    logic [SB_W-1:0]  sb_reg;
    logic [WIU_W-1:0] wiu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lob_reg <= LOB_RESET;
            sb_reg  <= SB_RESET;
            wiu_reg <= WIU_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_OFFSET: lob_reg <= cfg_wr_data[LOB_W-1:0];
                CFG_SET_BITS:    sb_reg  <= cfg_wr_data[SB_W-1:0];
                CFG_WAYS_IN_USE: wiu_reg <= cfg_wr_data[WIU_W-1:0];
                default: ;
            endcase
        end
    end

    // post-reset clearing sweep of the set memory
    logic              clr_active_reg;
    logic [SET_IW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + SET_IW'(1);
            if (clr_addr_reg == LAST_SET) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // address decode in the accept cycle
    logic [SET_IW-1:0] in_set;
    logic [TAG_W-1:0]  in_tag;

    samb_addr_split #(
        .ADDR_BITS (ADDR_BITS),
        .SET_BITS  (SET_BITS),
        .SET_IW    (SET_IW)
    ) u_split (
        .phys_addr        (s_phys_addr[ADDR_BITS-1:0]),
        .line_offset_bits (lob_reg),
        .set_bits         (sb_reg),
        .set_idx          (in_set),
        .tag              (in_tag)
    );

    // handshake
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s1_advance;
    logic accept;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !clr_active_reg && (!s1_valid_reg || s1_advance);
    assign accept     = s_valid && s_ready;

    // resolve stage registers
    logic              s1_req_reg;
    logic [SET_IW-1:0] s1_set_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic              fwd_hit_reg;
    logic [ROW_W-1:0]  fwd_row_reg;

    logic [ROW_W-1:0]  ram_row;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  row_new;
    logic              sel_hit;
    logic [WAY_W-1:0]  sel_way;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // the memory read at accept misses a write-back on the same edge: forward it
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg  <= s_req_type;
            s1_set_reg  <= in_set;
            s1_tag_reg  <= in_tag;
            fwd_hit_reg <= s1_advance && (s1_set_reg == in_set);
            fwd_row_reg <= row_new;
        end
    end

    assign cur_row = fwd_hit_reg ? fwd_row_reg : ram_row;

    samb_tag_ram #(
        .DEPTH (SETS),
        .AW    (SET_IW),
        .DW    (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (ram_row),
        .wr_en   (clr_active_reg || s1_advance),
        .wr_addr (clr_active_reg ? clr_addr_reg : s1_set_reg),
        .wr_data (clr_active_reg ? '0 : row_new)
    );

    samb_way_logic #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W),
        .ROW_W (ROW_W)
    ) u_ways (
        .req_type    (s1_req_reg),
        .tag         (s1_tag_reg),
        .ways_in_use (wiu_reg),
        .row_in      (cur_row),
        .hit         (sel_hit),
        .way         (sel_way),
        .row_out     (row_new)
    );

    // hit / miss counters, wrap at 32 bits
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;

    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (s1_req_reg == REQ_LOOKUP) begin
            if (sel_hit) begin
                hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end else begin
                miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else if (s1_advance) begin
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // result register
    logic [WAY_W+WAY_OUT_W-1:0]  way_ext;
    logic [SET_IW+SET_OUT_W-1:0] set_ext;
    logic                        m_hit_reg;
    logic [WAY_OUT_W-1:0]        m_way_reg;
    logic [SET_OUT_W-1:0]        m_set_reg;
    logic [CNT_W-1:0]            m_hit_total_reg;
    logic [CNT_W-1:0]            m_miss_total_reg;

    assign way_ext = {{WAY_OUT_W{1'b0}}, sel_way};
    assign set_ext = {{SET_OUT_W{1'b0}}, s1_set_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_hit_reg        <= sel_hit;
            m_way_reg        <= way_ext[WAY_OUT_W-1:0];
            m_set_reg        <= set_ext[SET_OUT_W-1:0];
            m_hit_total_reg  <= hit_cnt_next;
            m_miss_total_reg <= miss_cnt_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_way_used   = m_way_reg;
    assign m_set_index  = m_set_reg;
    assign m_hit_total  = m_hit_total_reg;
    assign m_miss_total = m_miss_total_reg;

`ifndef NO_ASSERTIONS
    // no item enters while the set memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !accept)
        else $error("item accepted during clearing sweep");

    // a lookup bumps exactly one of the two counters by one
    a_lookup_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_req_reg == REQ_LOOKUP) |=>
        (CNT_W'(hit_cnt_reg + miss_cnt_reg) ==
         CNT_W'($past(hit_cnt_reg) + $past(miss_cnt_reg) + CNT_W'(1))))
        else $error("lookup did not advance counters by one");

    // an invalidate leaves the counters alone
    a_inval_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_req_reg == REQ_INVAL) |=>
        ($stable(hit_cnt_reg) && $stable(miss_cnt_reg)))
        else $error("invalidate changed counters");

    // after a lookup the chosen way is valid, marked and holds the tag
    a_lookup_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && s1_req_reg == REQ_LOOKUP) |->
        (row_new[VLD_LO + sel_way] && row_new[MRU_LO + sel_way] &&
         row_new[sel_way*TAG_W +: TAG_W] == s1_tag_reg))
        else $error("lookup left chosen way inconsistent");

    // the result register only loads when its previous item has gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(m_hit_total_reg) && m_valid_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### sim/cache_tag_checker.sv
// Checker for the cache tag store: predicts each item's result and compares the outputs.
`default_nettype none

module cache_tag_checker
    import samb_pkg::*;
#(
    parameter int SETS      = DEF_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic                  s_req_type,
    input  wire logic [PADDR_W-1:0]    s_phys_addr,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  m_hit,
    input  wire logic [WAY_OUT_W-1:0]  m_way_used,
    input  wire logic [SET_OUT_W-1:0]  m_set_index,
    input  wire logic [CNT_W-1:0]      m_hit_total,
    input  wire logic [CNT_W-1:0]      m_miss_total,
    output int                         err_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SB = $clog2(SETS);
    localparam logic [PADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= PADDR_W) ? '1 : ((PADDR_W'(1) << ADDR_BITS) - PADDR_W'(1));

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [SET_OUT_W-1:0] set_idx;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
    } tag_result_t;

    logic [PADDR_W-1:0] tag_mem    [SETS*WAYS];
    logic               line_valid [SETS*WAYS];
    logic               line_mru   [SETS*WAYS];
    logic [CNT_W-1:0]   hit_count;
    logic [CNT_W-1:0]   miss_count;
    logic [LOB_W-1:0]   off_cfg;
    logic [SB_W-1:0]    sb_cfg;
    logic [WIU_W-1:0]   ways_cfg;

    tag_result_t result_q[$];

    // set the MRU bit; if that marks every way in use, keep only this one
    function automatic void touch_way(input int base, input int way, input int nw);
        int marked;
        marked = 0;
        line_mru[base + way] = 1'b1;
        for (int j = 0; j < nw; j++)
            if (line_mru[base + j]) marked++;
        if (marked == nw)
            for (int j = 0; j < nw; j++) line_mru[base + j] = 1'b0;
        line_mru[base + way] = 1'b1;
    endfunction

    function automatic tag_result_t predict_access(input logic inval,
                                                   input logic [PADDR_W-1:0] addr_in);
        tag_result_t      r;
        int               off, sb, nw, base, way;
        logic [PADDR_W-1:0] addr, line, set_sel, tag;
        logic             hit, found;
        addr  = addr_in & ADDR_MASK;
        off   = (off_cfg > OFF_MAX) ? int'(OFF_MAX) : int'(off_cfg);
        sb    = (sb_cfg > MAX_SB) ? MAX_SB : int'(sb_cfg);
        nw    = int'(ways_cfg);
        if (nw < 1) nw = 1;
        if (nw > WAYS) nw = WAYS;
        line    = addr >> off;
        set_sel = line & ((PADDR_W'(1) << sb) - PADDR_W'(1));
        tag     = line >> sb;
        base    = int'(set_sel) * WAYS;
        way     = 0;
        hit     = 1'b0;
        found   = 1'b0;

        if (inval == REQ_INVAL) begin
            // tags compare whether the way is valid or not
            for (int w = 0; w < nw; w++) begin
                if (tag_mem[base + w] == tag) begin
                    if (!hit) way = w;
                    hit = 1'b1;
                    line_valid[base + w] = 1'b0;
                    line_mru[base + w]   = 1'b0;
                end
            end
        end else begin
            for (int w = 0; w < nw && !hit; w++) begin
                if (line_valid[base + w] && tag_mem[base + w] == tag) begin
                    hit = 1'b1;
                    way = w;
                end
            end
            if (hit) begin
                touch_way(base, way, nw);
                hit_count++;
            end else begin
                for (int w = 0; w < nw && !found; w++) begin
                    if (!line_valid[base + w]) begin
                        found = 1'b1;
                        way   = w;
                    end
                end
                if (!found && nw > 1) begin
                    for (int w = 0; w < nw && !found; w++) begin
                        if (!line_mru[base + w]) begin
                            found = 1'b1;
                            way   = w;
                        end
                    end
                    // every way valid and marked: clear the row, take way 0
                    if (!found) begin
                        for (int w = 0; w < nw; w++) line_mru[base + w] = 1'b0;
                        way = 0;
                    end
                end
                line_valid[base + way] = 1'b1;
                tag_mem[base + way]    = tag;
                touch_way(base, way, nw);
                miss_count++;
            end
        end

        r.hit     = hit;
        r.way     = WAY_OUT_W'(way);
        r.set_idx = set_sel[SET_OUT_W-1:0];
        r.hits    = hit_count;
        r.misses  = miss_count;
        return r;
    endfunction

    always @(posedge aclk) begin
        tag_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < SETS*WAYS; i++) begin
                tag_mem[i]    = '0;
                line_valid[i] = 1'b0;
                line_mru[i]   = 1'b0;
            end
            hit_count  = '0;
            miss_count = '0;
            off_cfg    = LOB_RESET;
            sb_cfg     = SB_RESET;
            ways_cfg   = WIU_RESET;
            result_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LINE_OFFSET: off_cfg  = cfg_wr_data[LOB_W-1:0];
                    CFG_SET_BITS:    sb_cfg   = cfg_wr_data[SB_W-1:0];
                    CFG_WAYS_IN_USE: ways_cfg = cfg_wr_data[WIU_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                result_q.push_back(predict_access(s_req_type, s_phys_addr));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result item with no request outstanding");
                    err_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_hit);
                        err_count++;
                    end
                    if (m_way_used !== want.way) begin
                        $error("way_used: expected %0d, got %0d", want.way, m_way_used);
                        err_count++;
                    end
                    if (m_set_index !== want.set_idx) begin
                        $error("set_index: expected %0d, got %0d", want.set_idx, m_set_index);
                        err_count++;
                    end
                    if (m_hit_total !== want.hits) begin
                        $error("hit_total: expected %0d, got %0d", want.hits, m_hit_total);
                        err_count++;
                    end
                    if (m_miss_total !== want.misses) begin
                        $error("miss_total: expected %0d, got %0d", want.misses, m_miss_total);
                        err_count++;
                    end
                end
            end
        end
        pending = result_q.size();
    end

endmodule

`default_nettype wire

### sim/tb.sv
// Top of the cache tag store testbench: clock, reset, stimulus and the final verdict.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import samb_pkg::*;

    localparam int TB_MAX_SB      = $clog2(DEF_SETS);
    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off to back the block up
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 110;   // 10 phases -> about 1100 random items
    localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep; spare settling after the drain

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    wire logic             s_ready;
    logic                  s_req_type;
    logic [PADDR_W-1:0]    s_phys_addr;
    wire logic             m_valid;
    logic                  m_ready;
    wire logic             m_hit;
    wire logic [WAY_OUT_W-1:0] m_way_used;
    wire logic [SET_OUT_W-1:0] m_set_index;
    wire logic [CNT_W-1:0] m_hit_total;
    wire logic [CNT_W-1:0] m_miss_total;

    int mismatches;
    int outstanding;

    // stimulus control shared between the sender and the receiver
    bit quiet  = 1'b0;      // no idling on either side
    bit hold_rx = 1'b0;     // one-shot request for a long receiver hold-off

    // current configuration as written, used only to shape addresses
    int cur_lob = LOB_RESET;
    int cur_sb  = SB_RESET;
    logic [PADDR_W-1:0] tag_salt;

    always #1 aclk = ~aclk;

    set_assoc_cache_mru_bits uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_phys_addr  (s_phys_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_way_used   (m_way_used),
        .m_set_index  (m_set_index),
        .m_hit_total  (m_hit_total),
        .m_miss_total (m_miss_total)
    );

    cache_tag_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_phys_addr  (s_phys_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_way_used   (m_way_used),
        .m_set_index  (m_set_index),
        .m_hit_total  (m_hit_total),
        .m_miss_total (m_miss_total),
        .err_count    (mismatches),
        .pending      (outstanding)
    );

    // Stall length: mostly short, now and then a long one.
    function automatic int rand_stall();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 65) return 0;
        return rand_stall();
    endfunction

    // Build an address from tag, set and byte offset under the current config.
    // Offset and set width clamp the same way the block clamps them.
    function automatic logic [PADDR_W-1:0] line_addr(input logic [PADDR_W-1:0] tag,
                                                     input int set_sel,
                                                     input logic [PADDR_W-1:0] low);
        int off, sb;
        off = (cur_lob > OFF_MAX) ? int'(OFF_MAX) : cur_lob;
        sb  = (cur_sb > TB_MAX_SB) ? TB_MAX_SB : cur_sb;
        return (tag << (off + sb))
             | (PADDR_W'(set_sel & ((1 << sb) - 1)) << off)
             | (low & ((PADDR_W'(1) << off) - PADDR_W'(1)));
    endfunction

    // Mostly a handful of tags per phase so sets fill up, hit and get
    // replaced; one in ten addresses is fully random to toggle every bit.
    function automatic logic [PADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 99) < 10) return $urandom;
        return line_addr(tag_salt ^ PADDR_W'($urandom_range(0, 5)),
                         $urandom_range(0, DEF_SETS - 1), $urandom);
    endfunction

    // Offer one item after an optional gap and hold it until accepted.
    // Valid stays high into the next call unless that call opens a gap.
    task automatic send_item(input logic req, input logic [PADDR_W-1:0] addr,
                             input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_phys_addr <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Write all three registers on back-to-back cycles; block must be idle.
    task automatic write_config(input int lob, input int sb, input int wiu);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_LINE_OFFSET;
        cfg_wr_data <= CFG_DATA_W'(lob);
        @(negedge aclk);
        cfg_index   <= CFG_SET_BITS;
        cfg_wr_data <= CFG_DATA_W'(sb);
        @(negedge aclk);
        cfg_index   <= CFG_WAYS_IN_USE;
        cfg_wr_data <= CFG_DATA_W'(wiu);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_lob = lob;
        cur_sb  = sb;
    endtask

    // Receiver: random back-pressure, a long hold-off once on request.
    initial begin
        int n;
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
            end else if (quiet || $urandom_range(0, 99) < 60) begin
                m_ready <= 1'b1;
            end else begin
                n = rand_stall();
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int lob, sb, wiu;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_LINE_OFFSET;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_req_type  = REQ_LOOKUP;
        s_phys_addr = '0;
        tag_salt    = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, reset config: 4-byte lines, 16 sets, 4 ways ----
        // the block clears its set memory first; send_item waits on s_ready
        quiet = 1'b1;
        send_item(REQ_LOOKUP, 32'h0000_0000, 0);   // cold miss, way 0
        send_item(REQ_LOOKUP, 32'h0000_0003, 0);   // same line, hit
        send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 0);   // all-ones address, set 15
        send_item(REQ_LOOKUP, 32'hFFFF_FFFC, 0);
        send_item(REQ_INVAL,  32'hFFFF_FFFF, 0);   // invalidate a live line
        send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 0);   // misses again after invalidate
        // invalidate of tag zero in a set never filled: zero tags still match
        send_item(REQ_INVAL,  line_addr(0, 5, 0), 0);
        send_item(REQ_INVAL,  32'h1234_5678, 0);   // no tag match
        // fill set 3, then a fifth tag forces MRU-bit replacement
        for (int t = 1; t <= 5; t++)
            send_item(REQ_LOOKUP, line_addr(t, 3, 0), 0);
        send_item(REQ_LOOKUP, line_addr(2, 3, 0), 0);
        // mark ways 0 and 1 of set 6 with four ways in use ...
        send_item(REQ_LOOKUP, line_addr(1, 6, 0), 0);
        send_item(REQ_LOOKUP, line_addr(2, 6, 0), 0);
        wait_drained();
        // ... then drop to two ways: both valid and marked, the miss
        // has to clear the row and take way 0
        write_config(2, 4, 2);
        send_item(REQ_LOOKUP, line_addr(3, 6, 0), 0);
        wait_drained();
        // offset above 12, set bits above 4, zero ways (direct mapped)
        write_config(15, 7, 0);
        send_item(REQ_LOOKUP, 32'hABCD_E000, 0);
        send_item(REQ_LOOKUP, 32'h5BCD_E000, 0);   // same set, evicts way 0
        send_item(REQ_INVAL,  32'hABCD_E000, 0);
        wait_drained();
        // byte lines, a single set, ways above the maximum
        write_config(0, 0, 7);
        send_item(REQ_LOOKUP, 32'h0000_0000, 0);
        send_item(REQ_LOOKUP, 32'h0000_0001, 0);
        send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 0);
        send_item(REQ_LOOKUP, 32'h0000_0000, 0);

        // ---- random phases, one configuration each ----
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin lob = 12; sb = 0; wiu = 4; end
                1: begin lob = 0;  sb = 4; wiu = 1; end
                2: begin lob = 13; sb = 5; wiu = 0; end
                3: begin lob = 3;  sb = 2; wiu = 3; end
                default: begin
                    lob = $urandom_range(0, 15);
                    sb  = $urandom_range(0, 7);
                    wiu = $urandom_range(0, 7);
                end
            endcase
            write_config(lob, sb, wiu);
            quiet    = (p % 4 == 3);
            tag_salt = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // receiver holds off while items keep coming: input stalls
                if (p == 1 && i == 20) hold_rx = 1'b1;
                // sender pauses until every result is back
                if (p == 2 && i == 50) wait_drained();
                send_item(($urandom_range(0, 99) < 15) ? REQ_INVAL : REQ_LOOKUP,
                          rand_addr(), pick_gap());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### set_assoc_cache_mru_bits.f
src/samb_pkg.sv
src/samb_tag_ram.sv
src/samb_addr_split.sv
src/samb_way_logic.sv
src/set_assoc_cache_mru_bits.sv
sim/cache_tag_checker.sv
sim/tb.sv
